### rtl/core/lrbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and arithmetic helpers for the log ratio base converter.
// No dependencies.
package lrbc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int LOG_FRAC      = 30;              // fraction bits of the internal log2
   localparam int LOGW          = 38;              // signed width of a Q30 log2 value
   localparam int EXPW          = LOGW - LOG_FRAC; // integer part of the log2
   localparam int QUOW          = 32;              // quotient bits
   localparam int REMW          = LOGW + QUOW + 1; // divider remainder width

   localparam logic signed [LOGW-1:0] LOG2_FLOOR_Q30  = -38'sd42802717581;
   localparam logic        [LOGW-1:0] PI_OVER_LN2_Q30 = 38'd4866584646;

   typedef enum logic [1:0] {
      CSR_REF_LEVEL = 2'd0,
      CSR_LOG_BASE  = 2'd1,
      CSR_CPLX_MODE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      CFG_NORM   = 4'b0001,
      CFG_SQUARE = 4'b0010,
      CFG_FINISH = 4'b0100,
      CFG_READY  = 4'b1000
   } cfg_state_type;

   typedef struct packed {
      logic [4:0]  msb;
      logic [31:0] mant;
   } norm_type;

   typedef struct packed {
      logic [31:0] mant;
      logic        hit;
   } sq_type;

   typedef struct packed {
      logic       xneg;
      logic       xzero;
      logic [4:0] msb;
   } smp_info_type;

   typedef struct packed {
      logic cplx_zero;
      logic want_im;
      logic neg_re;
   } div_info_type;

   typedef struct packed {
      logic [31:0] val;
      logic        ovf;
   } sat_type;

   // leading one position and mantissa in [1,2) with 31 fraction bits
   function automatic norm_type normalize(input logic [31:0] v);
      norm_type r;
      r.msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) r.msb = 5'(i);
      end
      r.mant = v << (5'd31 - r.msb);
      return r;
   endfunction

   // one squaring step of the log2 bit recurrence
   function automatic sq_type square_step(input logic [31:0] m);
      logic [63:0] prod;
      logic [32:0] t;
      sq_type      r;
      prod = 64'(m) * 64'(m);
      t    = prod[63:31];
      if (t[32]) begin
         r.mant = t[32:1];
         r.hit  = 1'b1;
      end else begin
         r.mant = t[31:0];
         r.hit  = 1'b0;
      end
      return r;
   endfunction

   function automatic logic signed [LOGW-1:0] log_assemble(input logic [4:0] msb,
                                                          input logic [LOG_FRAC-1:0] frac,
                                                          input int frac_bits);
      logic signed [EXPW-1:0] e;
      e = $signed(EXPW'(msb)) - EXPW'(frac_bits);
      return {e, frac};
   endfunction

   function automatic sat_type sat_quot(input logic [31:0] q, input logic pre,
                                        input logic neg);
      sat_type r;
      if (!neg) begin
         if (pre || q[31]) r = '{val: 32'h7FFF_FFFF, ovf: 1'b1};
         else              r = '{val: q, ovf: 1'b0};
      end else begin
         if (pre || (q[31] && (q[30:0] != 31'd0))) r = '{val: 32'h8000_0000, ovf: 1'b1};
         else                                       r = '{val: 32'd0 - q, ovf: 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/log_ratio_base_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Log ratio base converter: n = (log2|x| - log2 x0) / log2 lambda, Q16.16 in and out.
// Depends on lrbc_pkg.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    req_sample
//   rsp      out  rsp_valid/ready    rsp_log_re, rsp_log_im, rsp_overflow, rsp_bad_base
//   csr      in   csr_we             csr_addr, csr_wdata
//
// One word per cycle while rsp is not stalled, through 68 register stages (input, normalize,
// 30 squaring, 2 numerator, range check, 32 restoring divide, output).
// After reset and after every register write the config logs are rebuilt by two iterative
// squaring units; req_ready stays low meanwhile.
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
module log_ratio_base_converter_top #(
   parameter int FRAC_BITS = lrbc_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_log_re,
   output logic signed [31:0]      rsp_log_im,
   output logic                    rsp_overflow,
   output logic                    rsp_bad_base,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_addr,
   input  wire logic [31:0]        csr_wdata
);

   localparam int SQ_N  = lrbc_pkg::LOG_FRAC;
   localparam int DIV_N = lrbc_pkg::QUOW;
   localparam int LW    = lrbc_pkg::LOGW;
   localparam int RW    = lrbc_pkg::REMW;
   localparam int LF    = lrbc_pkg::LOG_FRAC;

   // ---------------- configuration registers and log engine ----------------
   logic [31:0] cfg_ref_ff, cfg_base_ff;
   logic        cfg_cplx_ff;
   lrbc_pkg::cfg_state_type cfg_state_ff, cfg_state_in;
   logic [4:0]  cfg_cnt_ff, cfg_cnt_in;
   logic [31:0] cfg_mx_ff, cfg_mb_ff;
   logic [LF-1:0] cfg_fx_ff, cfg_fb_ff;
   logic [4:0]  cfg_px_ff, cfg_pb_ff;
   logic signed [LW-1:0] lx0_ff;
   logic [LW-1:0] den_mag_ff;
   logic        den_neg_ff;
   logic        bad_ff;

   lrbc_pkg::norm_type nx, nb;
   lrbc_pkg::sq_type   sx, sb;
   logic signed [LW-1:0] lb;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ref_ff  <= 32'd65536;
         cfg_base_ff <= 32'd131072;
         cfg_cplx_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (lrbc_pkg::csr_index_type'(csr_addr))
            lrbc_pkg::CSR_REF_LEVEL: cfg_ref_ff  <= csr_wdata;
            lrbc_pkg::CSR_LOG_BASE:  cfg_base_ff <= csr_wdata;
            lrbc_pkg::CSR_CPLX_MODE: cfg_cplx_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nx = lrbc_pkg::normalize((cfg_ref_ff != 32'd0) ? cfg_ref_ff : 32'd1);
      nb = lrbc_pkg::normalize(cfg_base_ff);
      sx = lrbc_pkg::square_step(cfg_mx_ff);
      sb = lrbc_pkg::square_step(cfg_mb_ff);
      lb = lrbc_pkg::log_assemble(cfg_pb_ff, cfg_fb_ff, FRAC_BITS);
   end

   always_comb begin
      cfg_state_in = cfg_state_ff;
      cfg_cnt_in   = cfg_cnt_ff;
      unique case (cfg_state_ff)
         lrbc_pkg::CFG_NORM: begin
            cfg_state_in = lrbc_pkg::CFG_SQUARE;
            cfg_cnt_in   = 5'd0;
         end
         lrbc_pkg::CFG_SQUARE: begin
            cfg_cnt_in = cfg_cnt_ff + 5'd1;
            if (cfg_cnt_ff == 5'(SQ_N - 1)) cfg_state_in = lrbc_pkg::CFG_FINISH;
         end
         lrbc_pkg::CFG_FINISH: cfg_state_in = lrbc_pkg::CFG_READY;
         lrbc_pkg::CFG_READY:  cfg_state_in = lrbc_pkg::CFG_READY;
         default:              cfg_state_in = lrbc_pkg::CFG_NORM;
      endcase
      // any write restarts the log rebuild
      if (csr_we) cfg_state_in = lrbc_pkg::CFG_NORM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff <= lrbc_pkg::CFG_NORM;
         cfg_cnt_ff   <= 5'd0;
      end else begin
         cfg_state_ff <= cfg_state_in;
         cfg_cnt_ff   <= cfg_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cfg_state_ff == lrbc_pkg::CFG_NORM) begin
         cfg_mx_ff <= nx.mant;
         cfg_px_ff <= nx.msb;
         cfg_mb_ff <= nb.mant;
         cfg_pb_ff <= nb.msb;
         cfg_fx_ff <= '0;
         cfg_fb_ff <= '0;
      end else if (cfg_state_ff == lrbc_pkg::CFG_SQUARE) begin
         cfg_mx_ff <= sx.mant;
         cfg_mb_ff <= sb.mant;
         cfg_fx_ff <= {cfg_fx_ff[LF-2:0], sx.hit};
         cfg_fb_ff <= {cfg_fb_ff[LF-2:0], sb.hit};
      end
      if (cfg_state_ff == lrbc_pkg::CFG_FINISH) begin
         lx0_ff     <= lrbc_pkg::log_assemble(cfg_px_ff, cfg_fx_ff, FRAC_BITS);
         den_neg_ff <= lb[LW-1];
         den_mag_ff <= lb[LW-1] ? LW'(-lb) : LW'(lb);
         bad_ff     <= (cfg_base_ff == 32'd0) || (cfg_base_ff == (32'd1 << FRAC_BITS));
      end
   end

   // ---------------- sample pipeline ----------------
   logic en;
   logic rsp_vld_ff;

   assign en        = !rsp_vld_ff || rsp_ready;
   assign req_ready = en && (cfg_state_ff == lrbc_pkg::CFG_READY);

   // stage A: input register
   logic        a_vld_ff;
   logic [31:0] a_smp_ff;

   // squaring stages, index 0 is the normalized word
   logic                   sq_vld_ff  [0:SQ_N];
   logic [31:0]            sq_mant_ff [0:SQ_N];
   logic [LF-1:0]          sq_frac_ff [0:SQ_N];
   lrbc_pkg::smp_info_type sq_info_ff [0:SQ_N];
   lrbc_pkg::sq_type       sq_step_in [1:SQ_N];

   // numerator stages
   logic                   c_vld_ff;
   logic signed [LW-1:0]   c_num_ff;
   lrbc_pkg::smp_info_type c_info_ff;
   logic                   d_vld_ff;
   logic [RW-1:0]          d_nre_ff;
   lrbc_pkg::div_info_type d_info_ff;

   // divider stages, index 0 holds the range check
   logic                   dv_vld_ff   [0:DIV_N];
   logic [RW-1:0]          dv_rre_ff   [0:DIV_N];
   logic [RW-1:0]          dv_rim_ff   [0:DIV_N];
   logic [31:0]            dv_qre_ff   [0:DIV_N];
   logic [31:0]            dv_qim_ff   [0:DIV_N];
   logic                   dv_ore_ff   [0:DIV_N];
   logic                   dv_oim_ff   [0:DIV_N];
   lrbc_pkg::div_info_type dv_info_ff  [0:DIV_N];
   logic [RW-1:0]          dv_rre_in   [1:DIV_N];
   logic [RW-1:0]          dv_rim_in   [1:DIV_N];
   logic [31:0]            dv_qre_in   [1:DIV_N];
   logic [31:0]            dv_qim_in   [1:DIV_N];

   lrbc_pkg::norm_type     a_norm;
   logic [31:0]            a_mag;
   logic signed [LW-1:0]   c_lx, c_diff, c_num_in;
   logic [LW-1:0]          d_mag;
   logic [RW-1:0]          den2, n_im, n_re_in;
   lrbc_pkg::sat_type      o_re, o_im;

   always_comb begin
      a_mag  = a_smp_ff[31] ? (32'd0 - a_smp_ff) : a_smp_ff;
      a_norm = lrbc_pkg::normalize(a_mag);
      for (int k = 1; k <= SQ_N; k++) begin
         sq_step_in[k] = lrbc_pkg::square_step(sq_mant_ff[k-1]);
      end
      c_lx   = lrbc_pkg::log_assemble(sq_info_ff[SQ_N].msb, sq_frac_ff[SQ_N], FRAC_BITS);
      c_diff = c_lx - lx0_ff;
      if (cfg_cplx_ff) begin
         c_num_in = c_diff;
      end else if (sq_info_ff[SQ_N].xneg || sq_info_ff[SQ_N].xzero ||
                   (c_diff < lrbc_pkg::LOG2_FLOOR_Q30)) begin
         c_num_in = lrbc_pkg::LOG2_FLOOR_Q30;
      end else begin
         c_num_in = c_diff;
      end
      den2    = RW'(den_mag_ff) << 1;
      n_im    = (RW'(lrbc_pkg::PI_OVER_LN2_Q30) << (FRAC_BITS + 1)) + RW'(den_mag_ff);
      d_mag   = c_num_ff[LW-1] ? LW'(-c_num_ff) : LW'(c_num_ff);
      n_re_in = (RW'(d_mag) << (FRAC_BITS + 1)) + RW'(den_mag_ff);
      // restoring divide, one quotient bit per stage
      for (int k = 1; k <= DIV_N; k++) begin
         if (dv_rre_ff[k-1] >= (den2 << (DIV_N - k))) begin
            dv_rre_in[k] = dv_rre_ff[k-1] - (den2 << (DIV_N - k));
            dv_qre_in[k] = {dv_qre_ff[k-1][30:0], 1'b1};
         end else begin
            dv_rre_in[k] = dv_rre_ff[k-1];
            dv_qre_in[k] = {dv_qre_ff[k-1][30:0], 1'b0};
         end
         if (dv_rim_ff[k-1] >= (den2 << (DIV_N - k))) begin
            dv_rim_in[k] = dv_rim_ff[k-1] - (den2 << (DIV_N - k));
            dv_qim_in[k] = {dv_qim_ff[k-1][30:0], 1'b1};
         end else begin
            dv_rim_in[k] = dv_rim_ff[k-1];
            dv_qim_in[k] = {dv_qim_ff[k-1][30:0], 1'b0};
         end
      end
      o_re = lrbc_pkg::sat_quot(dv_qre_ff[DIV_N], dv_ore_ff[DIV_N],
                                dv_info_ff[DIV_N].neg_re);
      o_im = lrbc_pkg::sat_quot(dv_qim_ff[DIV_N], dv_oim_ff[DIV_N], den_neg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= SQ_N; k++) sq_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= DIV_N; k++) dv_vld_ff[k] <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= req_valid && req_ready;
         sq_vld_ff[0] <= a_vld_ff;
         for (int k = 1; k <= SQ_N; k++) sq_vld_ff[k] <= sq_vld_ff[k-1];
         c_vld_ff     <= sq_vld_ff[SQ_N];
         d_vld_ff     <= c_vld_ff;
         dv_vld_ff[0] <= d_vld_ff;
         for (int k = 1; k <= DIV_N; k++) dv_vld_ff[k] <= dv_vld_ff[k-1];
         rsp_vld_ff   <= dv_vld_ff[DIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_smp_ff            <= req_sample;
         sq_mant_ff[0]       <= a_norm.mant;
         sq_frac_ff[0]       <= '0;
         sq_info_ff[0].xneg  <= a_smp_ff[31];
         sq_info_ff[0].xzero <= (a_mag == 32'd0);
         sq_info_ff[0].msb   <= a_norm.msb;
         for (int k = 1; k <= SQ_N; k++) begin
            sq_mant_ff[k] <= sq_step_in[k].mant;
            sq_frac_ff[k] <= {sq_frac_ff[k-1][LF-2:0], sq_step_in[k].hit};
            sq_info_ff[k] <= sq_info_ff[k-1];
         end
         c_num_ff  <= c_num_in;
         c_info_ff <= sq_info_ff[SQ_N];
         d_nre_ff  <= n_re_in;
         d_info_ff.cplx_zero <= cfg_cplx_ff && c_info_ff.xzero;
         d_info_ff.want_im   <= cfg_cplx_ff && c_info_ff.xneg;
         d_info_ff.neg_re    <= c_num_ff[LW-1] ^ den_neg_ff;
         // quotient at or above 2^32 saturates either way
         dv_rre_ff[0]  <= d_nre_ff;
         dv_rim_ff[0]  <= n_im;
         dv_qre_ff[0]  <= '0;
         dv_qim_ff[0]  <= '0;
         dv_ore_ff[0]  <= d_nre_ff >= (den2 << DIV_N);
         dv_oim_ff[0]  <= n_im >= (den2 << DIV_N);
         dv_info_ff[0] <= d_info_ff;
         for (int k = 1; k <= DIV_N; k++) begin
            dv_rre_ff[k]  <= dv_rre_in[k];
            dv_rim_ff[k]  <= dv_rim_in[k];
            dv_qre_ff[k]  <= dv_qre_in[k];
            dv_qim_ff[k]  <= dv_qim_in[k];
            dv_ore_ff[k]  <= dv_ore_ff[k-1];
            dv_oim_ff[k]  <= dv_oim_ff[k-1];
            dv_info_ff[k] <= dv_info_ff[k-1];
         end
         if (bad_ff) begin
            rsp_log_re   <= '0;
            rsp_log_im   <= '0;
            rsp_overflow <= 1'b0;
         end else begin
            if (dv_info_ff[DIV_N].cplx_zero) begin
               rsp_log_re <= den_neg_ff ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else begin
               rsp_log_re <= $signed(o_re.val);
            end
            rsp_log_im   <= dv_info_ff[DIV_N].want_im ? $signed(o_im.val) : 32'sd0;
            rsp_overflow <= dv_info_ff[DIV_N].cplx_zero ||
                            (!dv_info_ff[DIV_N].cplx_zero && o_re.ovf) ||
                            (dv_info_ff[DIV_N].want_im && o_im.ovf);
         end
         rsp_bad_base <= bad_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;

   // ---------------- assertions ----------------
   a_no_accept_while_rebuild: assert property (@(posedge clock) disable iff (reset)
      (cfg_state_ff != lrbc_pkg::CFG_READY) |-> !req_ready)
      else $error("sample accepted while config logs rebuild");

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (cfg_state_ff == lrbc_pkg::CFG_NORM))
      else $error("register write did not restart log rebuild");

   a_bad_base_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_base) |->
         (rsp_log_re == 32'sd0 && rsp_log_im == 32'sd0 && !rsp_overflow))
      else $error("bad base word carries a result");

   a_imag_needs_cplx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_log_im != 32'sd0) |-> cfg_cplx_ff)
      else $error("imaginary part outside complex mode");

endmodule
`default_nettype wire

### sim/tb_log_ratio_base_converter_top.sv
`timescale 1ns / 1ps
// Self-checking bench for log_ratio_base_converter_top: random bursts of samples,
// a predicting scoreboard, and register sweeps between drained phases.
// Depends on lrbc_pkg and the converter RTL.
module tb_log_ratio_base_converter_top;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        ovf;
      logic        bad;
   } conv_word_type;

   class conv_scoreboard_type;
      logic [31:0]   ref_level = 32'd65536;
      logic [31:0]   base      = 32'd131072;
      logic          cplx      = 1'b0;
      conv_word_type pending[$];
      int            errors = 0;

      function void set_reg(logic [1:0] idx, logic [31:0] d);
         if (idx == lrbc_pkg::CSR_REF_LEVEL) ref_level = d;
         else if (idx == lrbc_pkg::CSR_LOG_BASE) base = d;
         else if (idx == lrbc_pkg::CSR_CPLX_MODE) cplx = d[0];
      endfunction

      // log2 by repeated squaring, Q30, truncated after the last fraction bit
      function longint log2_q30(logic [31:0] v);
         int          p;
         logic [63:0] m;
         longint      frac;
         p = 31;
         frac = 0;
         while (p > 0 && !v[p]) p--;
         m = 64'(v) << (31 - p);
         for (int i = 0; i < lrbc_pkg::LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               m = m >> 1;
               frac = frac | 1;
            end
         end
         return (longint'(p) - 16) * (64'sd1 <<< lrbc_pkg::LOG_FRAC) + frac;
      endfunction

      function logic [31:0] quot_sat(logic [63:0] mag, bit neg, logic [63:0] d,
                                     inout logic ovf);
         logic [63:0] q;
         q = ((mag << 16) * 2 + d) / (2 * d);
         if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
               ovf = 1'b1;
               return 32'h7FFF_FFFF;
            end
            return q[31:0];
         end
         if (q > 64'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
         end
         return 32'd0 - q[31:0];
      endfunction

      function void note_sample(logic [31:0] xs);
         conv_word_type w;
         bit          xneg, dneg;
         logic [31:0] xmag, x0;
         longint      den, num;
         logic [63:0] dmag;
         w = '{re: 32'd0, im: 32'd0, ovf: 1'b0, bad: 1'b0};
         xneg = xs[31];
         xmag = xneg ? 32'd0 - xs : xs;
         x0 = (ref_level != 0) ? ref_level : 32'd1;
         if (base == 0 || base == ONE_Q16) begin
            w.bad = 1'b1;
         end else begin
            den = log2_q30(base);
            dneg = den < 0;
            dmag = dneg ? -den : den;
            if (cplx) begin
               if (xmag == 0) begin
                  w.ovf = 1'b1;
                  w.re = dneg ? 32'h7FFF_FFFF : 32'h8000_0000;
               end else begin
                  num = log2_q30(xmag) - log2_q30(x0);
                  w.re = quot_sat(num < 0 ? -num : num, (num < 0) != dneg, dmag, w.ovf);
               end
               if (xneg) w.im = quot_sat(64'(lrbc_pkg::PI_OVER_LN2_Q30), dneg, dmag, w.ovf);
            end else begin
               // clamp the log difference at the floor
               if (xneg || xmag == 0) begin
                  num = longint'(lrbc_pkg::LOG2_FLOOR_Q30);
               end else begin
                  num = log2_q30(xmag) - log2_q30(x0);
                  if (num < longint'(lrbc_pkg::LOG2_FLOOR_Q30))
                     num = longint'(lrbc_pkg::LOG2_FLOOR_Q30);
               end
               w.re = quot_sat(num < 0 ? -num : num, (num < 0) != dneg, dmag, w.ovf);
            end
         end
         pending.push_back(w);
      endfunction

      function void check_word(conv_word_type got);
         conv_word_type exp_w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word re=%h im=%h", $realtime, got.re, got.im);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.re !== exp_w.re) begin
            $display("%0t: log_re expected %h actual %h", $realtime, exp_w.re, got.re);
            errors++;
         end
         if (got.im !== exp_w.im) begin
            $display("%0t: log_im expected %h actual %h", $realtime, exp_w.im, got.im);
            errors++;
         end
         if (got.ovf !== exp_w.ovf) begin
            $display("%0t: overflow expected %b actual %b", $realtime, exp_w.ovf, got.ovf);
            errors++;
         end
         if (got.bad !== exp_w.bad) begin
            $display("%0t: bad_base expected %b actual %b", $realtime, exp_w.bad, got.bad);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_log_re;
   logic signed [31:0] rsp_log_im;
   logic               rsp_overflow;
   logic               rsp_bad_base;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_addr = '0;
   logic [31:0]        csr_wdata = '0;

   conv_scoreboard_type sb = new();
   int  stall_pct = 0;
   int  gap_max = 0;
   bit  long_hold = 1'b0;

   log_ratio_base_converter_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_sample(req_sample);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word('{re: rsp_log_re, im: rsp_log_im, ovf: rsp_overflow,
                         bad: rsp_bad_base});
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // one write, with csr_we low again before the task returns, so back-to-back writes never collide on csr_we
   task automatic write_csr(logic [1:0] idx, logic [31:0] d);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, d);
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   int burst_left = 0;

   // hold valid through the burst, drop it for a random gap after
   task automatic send_sample(logic [31:0] s);
      int gap;
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(0, 6))
         0: v = $urandom;
         1: v = $urandom_range(1, 32'h3FFFF);
         2: v = 32'd0 - $urandom_range(1, 32'h3FFFF);
         3: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ $urandom_range(0, 3);
         4: v = $urandom >> $urandom_range(0, 31);
         5: v = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
         default: v = sb.ref_level + $urandom_range(0, 7) - 3;
      endcase
      return v;
   endfunction

   task automatic set_all(logic [31:0] r, logic [31:0] b, logic c);
      write_csr(lrbc_pkg::CSR_REF_LEVEL, r);
      write_csr(lrbc_pkg::CSR_LOG_BASE, b);
      write_csr(lrbc_pkg::CSR_CPLX_MODE, {31'd0, c});
   endtask

   logic [31:0] directed[12] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0002, 32'h0002_0000,
                                 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
   logic [31:0] ph_ref[11] = '{32'd65536, 32'd0, 32'd65536, 32'd65536, 32'd1, 32'hFFFF_FFFF,
                               32'd65536, 32'd65536, 32'd300, 32'd0, 32'd0};
   logic [31:0] ph_base[11] = '{32'd131072, 32'd131072, 32'd0, 32'd65536, 32'd1,
                                32'hFFFF_FFFF, 32'd65537, 32'd65537, 32'd32768, 32'd0, 32'd0};
   logic        ph_cplx[11] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                1'b0, 1'b1};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: both modes at the field extremes, plus an ignored register index
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      foreach (directed[i]) send_sample(directed[i]);
      req_valid <= 1'b0;
      drain();
      write_csr(lrbc_pkg::CSR_CPLX_MODE, 32'd1);
      foreach (directed[i]) send_sample(directed[i]);
      req_valid <= 1'b0;
      drain();
      for (int ph = 0; ph < 11; ph++) begin
         if (ph >= 9) set_all($urandom, $urandom, 1'($urandom_range(0, 1)));
         else set_all(ph_ref[ph], ph_base[ph], ph_cplx[ph]);
         stall_pct = (ph == 0) ? 0 : $urandom_range(10, 70);
         gap_max = (ph == 1) ? 0 : $urandom_range(1, 8);
         if (ph == 2) long_hold = 1'b1;
         // the hold-off phase offers more words than the pipeline holds
         for (int n = 0; n < ((ph == 2) ? 120 : 41); n++) send_sample(pick_sample());
         req_valid <= 1'b0;
         drain();
      end
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### log_ratio_base_converter_top.f
rtl/core/lrbc_pkg.sv
rtl/core/log_ratio_base_converter_top.sv
sim/tb_log_ratio_base_converter_top.sv
